### design/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types and codes for the canonical Huffman decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_BUILD  = 2'd1,
        FUNC_DECODE = 2'd2,
        FUNC_FINISH = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_BUILT  = 2'd0,
        KIND_SYMBOL = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_FINISH = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_TOTAL = 3'd1,
        ERR_OVERSUB   = 3'd2,
        ERR_NO_CODE   = 3'd3,
        ERR_INDEX     = 3'd4,
        ERR_TRUNC     = 3'd5,
        ERR_NO_TABLE  = 3'd6
    } t_err;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COUNT,
        ST_COUNT_WAIT,
        ST_CHECK,
        ST_OFFSETS,
        ST_FILL,
        ST_FILL_WAIT,
        ST_BUILD_DONE,
        ST_BIT,
        ST_LOOKUP,
        ST_EMIT
    } t_state;

endpackage

### design/chd_if.sv
// ----------------------------------------------------------------------------
// chd_in_if / chd_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface chd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [8:0] load_sym;
    logic [3:0] code_length;
    logic [8:0] symbol_total;
    logic [7:0] data_byte;
    modport source (output valid, func, load_sym, code_length, symbol_total,
                    data_byte, input ready);
    modport sink (input valid, func, load_sym, code_length, symbol_total,
                  data_byte, output ready);
endinterface

interface chd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [8:0] symbol;
    logic [2:0] error_code;
    logic       last;
    modport source (output valid, kind, symbol, error_code, last, input ready);
    modport sink (input valid, kind, symbol, error_code, last, output ready);
endinterface

### design/canonical_huffman_decoder_top.sv
// ----------------------------------------------------------------------------
// canonical_huffman_decoder_top
// Iterative DEFLATE canonical Huffman decoder with sequencer and one ALU path.
// ----------------------------------------------------------------------------
// A load item writes one length into the length memory. A build item walks
// the loaded lengths twice (once for counting and again for filling), with
// the length checks and running offsets in between and a hand-off state at
// the end, and stops early when a check fails. A decode item shifts one code
// bit per cycle through the shared compare/add unit while the output is free;
// a symbol found passes a lookup and an emit state, and a held symbol goes out
// ahead of a later result of the same byte. A decoded symbol is held until the
// next result or the end of the byte shows whether it is the last one. The
// block takes one item at a time; the output register holds a result while
// the sequencer waits for it to drain.
module canonical_huffman_decoder_top #(
    parameter int MAX_SYMBOLS     = 288,
    parameter int MAX_CODE_LENGTH = 15
) (
    input  logic i_clk,
    input  logic i_rst_n,
    chd_in_if.sink    i_in,
    chd_out_if.source o_out
);
    localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    // length and sorted symbol memories
    logic [3:0] r_len_mem [MAX_SYMBOLS];
    logic [8:0] r_sym_mem [MAX_SYMBOLS];
    logic [3:0] r_len_rd;
    logic [8:0] r_sym_rd;
    logic       len_we, sym_we;
    logic [AW-1:0] len_waddr, len_raddr, sym_waddr, sym_raddr;
    logic [3:0] len_wdata;
    logic [8:0] sym_wdata;

    always_ff @(posedge i_clk) begin
        if (len_we) r_len_mem[len_waddr] <= len_wdata;
        r_len_rd <= r_len_mem[len_raddr];
        if (sym_we) r_sym_mem[sym_waddr] <= sym_wdata;
        r_sym_rd <= r_sym_mem[sym_raddr];
    end

    // state
    chd_pkg::t_state r_st, n_st;
    logic [8:0]  r_cnt [16];
    logic [8:0]  r_off [16];
    logic [8:0]  r_used, n_used;
    logic        r_tv, n_tv;
    logic [15:0] r_pc, n_pc, r_fc, n_fc;
    logic [8:0]  r_ib, n_ib;
    logic [3:0]  r_cbt, n_cbt;
    logic [2:0]  r_bp, n_bp;
    logic [9:0]  r_s, n_s;
    logic [9:0]  r_tot, n_tot;
    logic [7:0]  r_byte, n_byte;
    logic [3:0]  r_b, n_b;
    logic [16:0] r_rem, n_rem;
    logic [9:0]  r_zero, n_zero;
    logic [8:0]  r_idx, n_idx;
    logic        r_ovf, n_ovf;
    logic        r_ov, n_ov;
    logic [1:0]  r_ok, n_ok;
    logic [8:0]  r_osym, n_osym;
    logic [2:0]  r_oerr, n_oerr;
    logic        r_olast, n_olast;
    logic        r_after_last, n_after_last;
    logic        r_hold, n_hold;
    logic [8:0]  r_hsym, n_hsym;

    // table update requests from the sequencer
    logic        cnt_clr, cnt_inc, off_wr, off_inc;
    logic [3:0]  cnt_sel, off_sel;
    logic [8:0]  off_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) begin
                r_cnt[k] <= '0;
                r_off[k] <= '0;
            end
        end else begin
            if (cnt_clr) begin
                for (int k = 0; k < 16; k++) r_cnt[k] <= '0;
            end else if (cnt_inc) begin
                r_cnt[cnt_sel] <= r_cnt[cnt_sel] + 9'd1;
            end
            if (cnt_clr) begin
                for (int k = 0; k < 16; k++) r_off[k] <= '0;
            end else if (off_wr) begin
                r_off[off_sel] <= off_val;
            end else if (off_inc) begin
                r_off[off_sel] <= r_off[off_sel] + 9'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= chd_pkg::ST_IDLE;
            r_used <= '0; r_tv <= 1'b0; r_pc <= '0; r_fc <= '0; r_ib <= '0;
            r_cbt <= '0; r_bp <= '0; r_ov <= 1'b0; r_hold <= 1'b0;
        end else begin
            r_st <= n_st;
            r_used <= n_used; r_tv <= n_tv; r_pc <= n_pc; r_fc <= n_fc; r_ib <= n_ib;
            r_cbt <= n_cbt; r_bp <= n_bp; r_ov <= n_ov; r_hold <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s; r_tot <= n_tot; r_byte <= n_byte; r_b <= n_b; r_rem <= n_rem;
        r_zero <= n_zero; r_idx <= n_idx; r_ovf <= n_ovf; r_ok <= n_ok;
        r_osym <= n_osym; r_oerr <= n_oerr; r_olast <= n_olast;
        r_after_last <= n_after_last; r_hsym <= n_hsym;
    end

    assign o_out.valid      = r_ov;
    assign o_out.kind       = r_ok;
    assign o_out.symbol     = r_osym;
    assign o_out.error_code = r_oerr;
    assign o_out.last       = r_olast;

    // shared compare/add unit for one code bit
    logic [3:0]  bit_len;
    logic [15:0] bit_code;
    logic [8:0]  bit_cnt;
    logic [15:0] bit_diff;
    logic        bit_hit;
    logic        bit_stop;
    always_comb begin
        bit_len  = r_cbt + 4'd1;
        bit_code = r_pc | {15'd0, r_byte[r_bp]};
        bit_cnt  = (r_cbt == 4'd15) ? 9'd0 : r_cnt[bit_len];
        bit_diff = bit_code - r_fc;
        bit_hit  = (bit_code >= r_fc) && (bit_diff < {7'd0, bit_cnt});
        bit_stop = bit_hit || ({1'b0, bit_len} >= 5'(MAX_CODE_LENGTH));
    end

    logic out_free;
    assign out_free = !r_ov || o_out.ready;

    always_comb begin
        n_st = r_st; n_used = r_used; n_tv = r_tv; n_pc = r_pc; n_fc = r_fc;
        n_ib = r_ib; n_cbt = r_cbt; n_bp = r_bp; n_s = r_s; n_tot = r_tot;
        n_byte = r_byte; n_b = r_b; n_rem = r_rem; n_zero = r_zero; n_idx = r_idx;
        n_ovf = r_ovf; n_ok = r_ok; n_osym = r_osym; n_oerr = r_oerr;
        n_olast = r_olast; n_after_last = r_after_last;
        n_hold = r_hold; n_hsym = r_hsym;
        n_ov = r_ov && !o_out.ready;
        i_in.ready = 1'b0;
        len_we = 1'b0; len_waddr = i_in.load_sym[AW-1:0];
        len_wdata = i_in.code_length; len_raddr = r_s[AW-1:0];
        sym_we = 1'b0; sym_waddr = r_off[r_len_rd][AW-1:0];
        sym_wdata = r_s[8:0] - 9'd1; sym_raddr = r_idx[AW-1:0];
        cnt_clr = 1'b0; cnt_inc = 1'b0; cnt_sel = r_len_rd;
        off_wr = 1'b0; off_inc = 1'b0; off_sel = r_b; off_val = '0;
        unique case (r_st)
            chd_pkg::ST_IDLE: begin
                i_in.ready = out_free;
                if (i_in.valid && out_free) begin
                    n_tot = {1'b0, i_in.symbol_total};
                    n_byte = i_in.data_byte;
                    n_s = '0; n_zero = '0; n_bp = '0; n_hold = 1'b0;
                    unique case (chd_pkg::t_func'(i_in.func))
                        chd_pkg::FUNC_LOAD: begin
                            len_we = {1'b0, i_in.load_sym} < 10'(MAX_SYMBOLS);
                        end
                        chd_pkg::FUNC_BUILD: begin
                            cnt_clr = 1'b1;
                            n_tv = 1'b0; n_used = '0;
                            n_pc = '0; n_fc = '0; n_ib = '0; n_cbt = '0;
                            if (i_in.symbol_total == 9'd0 ||
                                {1'b0, i_in.symbol_total} > 10'(MAX_SYMBOLS)) begin
                                n_ov = 1'b1; n_ok = chd_pkg::KIND_ERROR;
                                n_osym = '0; n_oerr = chd_pkg::ERR_BAD_TOTAL;
                                n_olast = 1'b1;
                            end else begin
                                n_st = chd_pkg::ST_COUNT;
                            end
                        end
                        chd_pkg::FUNC_DECODE: begin
                            if (!r_tv) begin
                                n_ov = 1'b1; n_ok = chd_pkg::KIND_ERROR;
                                n_osym = '0; n_oerr = chd_pkg::ERR_NO_TABLE;
                                n_olast = 1'b1;
                            end else begin
                                n_st = chd_pkg::ST_BIT;
                            end
                        end
                        chd_pkg::FUNC_FINISH: begin
                            n_ov = 1'b1; n_osym = '0; n_olast = 1'b1;
                            if (r_cbt != 4'd0) begin
                                n_ok = chd_pkg::KIND_ERROR; n_oerr = chd_pkg::ERR_TRUNC;
                            end else begin
                                n_ok = chd_pkg::KIND_FINISH; n_oerr = chd_pkg::ERR_NONE;
                            end
                            n_pc = '0; n_fc = '0; n_ib = '0; n_cbt = '0;
                        end
                        default: ;
                    endcase
                end
            end
            // read each length through the count and wait states and count it
            chd_pkg::ST_COUNT: begin
                n_s = r_s + 10'd1;
                n_st = chd_pkg::ST_COUNT_WAIT;
            end
            chd_pkg::ST_COUNT_WAIT: begin
                if (r_len_rd == 4'd0) n_zero = r_zero + 10'd1;
                if ({1'b0, r_len_rd} > 5'(MAX_CODE_LENGTH)) n_ovf = 1'b1;
                else cnt_inc = 1'b1;
                if (r_s == r_tot) begin
                    n_st = chd_pkg::ST_CHECK; n_b = 4'd1; n_rem = 17'd1;
                end else begin
                    n_st = chd_pkg::ST_COUNT;
                end
                if (r_s == 10'd1) n_ovf = ({1'b0, r_len_rd} > 5'(MAX_CODE_LENGTH));
            end
            // bad-length and over-subscription checks, one code length per cycle
            chd_pkg::ST_CHECK: begin
                if (r_ovf || r_zero == r_tot) begin
                    cnt_clr = 1'b1;
                    n_ov = 1'b1; n_ok = chd_pkg::KIND_ERROR; n_osym = '0;
                    n_oerr = chd_pkg::ERR_BAD_TOTAL; n_olast = 1'b1;
                    n_st = chd_pkg::ST_BUILD_DONE;
                end else if ({r_rem[15:0], 1'b0} < {8'd0, r_cnt[r_b]}) begin
                    cnt_clr = 1'b1;
                    n_ov = 1'b1; n_ok = chd_pkg::KIND_ERROR; n_osym = '0;
                    n_oerr = chd_pkg::ERR_OVERSUB; n_olast = 1'b1;
                    n_st = chd_pkg::ST_BUILD_DONE;
                end else begin
                    n_rem = {r_rem[15:0], 1'b0} - {8'd0, r_cnt[r_b]};
                    if (r_b == 4'd15) begin
                        n_b = 4'd1; n_st = chd_pkg::ST_OFFSETS;
                    end else begin
                        n_b = r_b + 4'd1;
                    end
                end
            end
            // running start offsets
            chd_pkg::ST_OFFSETS: begin
                off_wr = 1'b1; off_sel = r_b + 4'd1;
                off_val = r_off[r_b] + r_cnt[r_b];
                if (r_b == 4'd14) begin
                    n_st = chd_pkg::ST_FILL; n_s = '0;
                end else begin
                    n_b = r_b + 4'd1;
                end
            end
            chd_pkg::ST_FILL: begin
                n_s = r_s + 10'd1;
                n_st = chd_pkg::ST_FILL_WAIT;
            end
            // place each used symbol at its offset
            chd_pkg::ST_FILL_WAIT: begin
                if (r_len_rd != 4'd0) begin
                    sym_we = {1'b0, r_off[r_len_rd]} < 10'(MAX_SYMBOLS);
                    off_inc = 1'b1; off_sel = r_len_rd;
                    n_used = r_used + 9'd1;
                end
                if (r_s == r_tot) begin
                    n_tv = 1'b1;
                    n_ov = 1'b1; n_ok = chd_pkg::KIND_BUILT; n_osym = '0;
                    n_oerr = chd_pkg::ERR_NONE; n_olast = 1'b1;
                    n_st = chd_pkg::ST_BUILD_DONE;
                end else begin
                    n_st = chd_pkg::ST_FILL;
                end
            end
            chd_pkg::ST_BUILD_DONE: n_st = chd_pkg::ST_IDLE;
            // one code bit through the compare/add unit
            chd_pkg::ST_BIT: begin
                if (out_free) begin
                    if (r_hold && bit_stop) begin
                        // held symbol goes out ahead of this bit's result
                        n_ov = 1'b1; n_ok = chd_pkg::KIND_SYMBOL; n_osym = r_hsym;
                        n_oerr = chd_pkg::ERR_NONE; n_olast = 1'b0;
                        n_hold = 1'b0;
                    end else begin
                        n_after_last = (r_bp == 3'd7);
                        if (bit_hit) begin
                            n_idx = r_ib + bit_diff[8:0];
                            n_pc = '0; n_fc = '0; n_ib = '0; n_cbt = '0;
                            if (r_ib + bit_diff[8:0] >= r_used ||
                                {1'b0, r_ib + bit_diff[8:0]} >= 10'(MAX_SYMBOLS) ||
                                bit_diff[15:9] != 7'd0) begin
                                n_ov = 1'b1; n_ok = chd_pkg::KIND_ERROR; n_osym = '0;
                                n_oerr = chd_pkg::ERR_INDEX; n_olast = 1'b1;
                                n_st = chd_pkg::ST_IDLE;
                            end else begin
                                n_st = chd_pkg::ST_LOOKUP;
                            end
                        end else begin
                            n_ib = r_ib + bit_cnt;
                            n_fc = (r_fc + {7'd0, bit_cnt}) << 1;
                            n_pc = bit_code << 1;
                            n_cbt = bit_len;
                            if ({1'b0, bit_len} >= 5'(MAX_CODE_LENGTH)) begin
                                n_pc = '0; n_fc = '0; n_ib = '0; n_cbt = '0;
                                n_ov = 1'b1; n_ok = chd_pkg::KIND_ERROR; n_osym = '0;
                                n_oerr = chd_pkg::ERR_NO_CODE; n_olast = 1'b1;
                                n_st = chd_pkg::ST_IDLE;
                            end else if (r_bp == 3'd7) begin
                                n_st = chd_pkg::ST_IDLE;
                                // byte ends quietly, so the held symbol is the last
                                if (r_hold) begin
                                    n_ov = 1'b1; n_ok = chd_pkg::KIND_SYMBOL;
                                    n_osym = r_hsym; n_oerr = chd_pkg::ERR_NONE;
                                    n_olast = 1'b1; n_hold = 1'b0;
                                end
                            end
                        end
                        n_bp = r_bp + 3'd1;
                    end
                end
            end
            chd_pkg::ST_LOOKUP: n_st = chd_pkg::ST_EMIT;
            // hold the symbol unless the byte is done
            chd_pkg::ST_EMIT: begin
                if (!r_after_last) begin
                    n_hold = 1'b1; n_hsym = r_sym_rd;
                    n_st = chd_pkg::ST_BIT;
                end else if (out_free) begin
                    n_ov = 1'b1; n_ok = chd_pkg::KIND_SYMBOL; n_osym = r_sym_rd;
                    n_oerr = chd_pkg::ERR_NONE; n_olast = 1'b1;
                    n_st = chd_pkg::ST_IDLE;
                end
            end
            default: n_st = chd_pkg::ST_IDLE;
        endcase
    end
endmodule
